@@ hw/rtl/u8san_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8san_pkg: shared types and constants of the UTF-8 stream sanitizer
// Payload structs, controller states, datapath commands and byte classing.
// ----------------------------------------------------------------------------
package u8san_pkg;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [1:0] REPL_LAST = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PASS,
    ST_REPL
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_HEAD,
    OP_PUSH_REPL,
    OP_DROP_HEAD,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] repl_idx;
  } cmd_t;

  typedef struct packed {
    logic [2:0] count;
    logic [2:0] head_len;
    logic       cont_ok;
    logic       can_push;
    logic       out_free;
    logic       pend_valid;
    logic       fin;
  } status_t;

  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if (c[7] == 1'b0) begin
      len = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = REPL_B0;
      2'd1:    b = REPL_B1;
      default: b = REPL_B2;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/utf8_stream_sanitizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer: byte-serial UTF-8 cleanup with U+FFFD replacement
// Input transactions carry one raw byte and a flag on the last byte of a
// string. Output transactions carry one cleaned byte each, with byte_valid,
// run_last (last result of the input transaction) and string_end (results
// of the final byte). A final byte that yields no data gives one empty
// marker with byte_valid low. Valid lead/continuation runs pass unchanged;
// bad leads become EF BF BD and the bytes after them are scanned again; an
// incomplete tail at the end of a string is dropped.
// An input transaction is taken only while the controller is idle. After
// acceptance the controller takes one step per output byte produced and
// one step per sequence examined (a bad lead is dropped in the step that
// examines it), plus a closing step. The last result leaves through the
// output register in the cycle after the closing step. A stalled receiver
// holds the output register and the controller waits on it; nothing is
// lost. Synchronous reset empties the hold buffer and the output register.
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  u8san_pkg::in_t   in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output u8san_pkg::out_t  out_data
);

  u8san_pkg::cmd_t    cmd;
  u8san_pkg::status_t status;

  u8san_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  u8san_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ hw/rtl/u8san_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8san_ctrl: sequencing of the sanitizer
// Accepts a byte, then walks the held sequence one output byte per cycle while the datapath can take a push.
// ----------------------------------------------------------------------------
module u8san_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  u8san_pkg::status_t  status,
  output u8san_pkg::cmd_t     cmd
);

  u8san_pkg::state_t state;
  u8san_pkg::state_t state_next;
  logic [1:0]        step;
  logic [1:0]        step_next;
  logic              scan_done;
  logic              need_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= u8san_pkg::ST_IDLE;
      step  <= 2'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign scan_done = (status.count == 3'd0) ||
                     ((status.head_len != 3'd0) && (status.count < status.head_len));
  assign need_out  = status.pend_valid || status.fin;

  always_comb begin
    state_next   = state;
    step_next    = step;
    in_ready     = 1'b0;
    cmd.op       = u8san_pkg::OP_NONE;
    cmd.repl_idx = step;
    case (state)
      u8san_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = u8san_pkg::OP_LOAD;
          state_next = u8san_pkg::ST_SCAN;
        end
      end
      u8san_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (!need_out || status.out_free) begin
            cmd.op     = u8san_pkg::OP_FLUSH;
            state_next = u8san_pkg::ST_IDLE;
          end
        end else if ((status.head_len == 3'd0) || !status.cont_ok) begin
          cmd.op     = u8san_pkg::OP_DROP_HEAD;
          step_next  = 2'd0;
          state_next = u8san_pkg::ST_REPL;
        end else begin
          step_next  = status.head_len[1:0] - 2'd1;
          state_next = u8san_pkg::ST_PASS;
        end
      end
      u8san_pkg::ST_PASS: begin
        if (status.can_push) begin
          cmd.op = u8san_pkg::OP_PUSH_HEAD;
          if (step == 2'd0) begin
            state_next = u8san_pkg::ST_SCAN;
          end else begin
            step_next = step - 2'd1;
          end
        end
      end
      u8san_pkg::ST_REPL: begin
        if (status.can_push) begin
          cmd.op = u8san_pkg::OP_PUSH_REPL;
          if (step == u8san_pkg::REPL_LAST) begin
            state_next = u8san_pkg::ST_SCAN;
          end else begin
            step_next = step + 2'd1;
          end
        end
      end
      default: begin
        state_next = u8san_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/u8san_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8san_dp: hold buffer, pending byte and output register
// The pending byte is kept back one step so that the last byte of a
// transaction's results can be marked once the scan is over.
// ----------------------------------------------------------------------------
module u8san_dp (
  input  wire                 clk,
  input  wire                 rst,
  input  u8san_pkg::cmd_t     cmd,
  input  u8san_pkg::in_t      in_data,
  output u8san_pkg::status_t  status,
  output logic                out_valid,
  input  wire                 out_ready,
  output u8san_pkg::out_t     out_data
);

  logic [7:0] held [4];
  logic [2:0] count;
  logic       fin;
  logic [7:0] pend_byte;
  logic       pend_valid;
  logic       out_free;
  logic       cont_ok;
  logic [2:0] head_len;
  logic       push;
  logic [7:0] push_byte;
  logic       out_load;

  assign head_len = u8san_pkg::seq_len(held[0]);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cont_ok = 1'b1;
    for (int j = 1; j < 4; j++) begin
      if ((3'(j) < head_len) && (held[j][7:6] != 2'b10)) begin
        cont_ok = 1'b0;
      end
    end
  end

  assign push      = (cmd.op == u8san_pkg::OP_PUSH_HEAD) ||
                     (cmd.op == u8san_pkg::OP_PUSH_REPL);
  assign push_byte = (cmd.op == u8san_pkg::OP_PUSH_HEAD) ? held[0]
                                                        : u8san_pkg::repl_byte(cmd.repl_idx);
  assign out_load  = (push && pend_valid) ||
                     ((cmd.op == u8san_pkg::OP_FLUSH) && (pend_valid || fin));

  always_comb begin
    status.count      = count;
    status.head_len   = head_len;
    status.cont_ok    = cont_ok;
    status.can_push   = !pend_valid || out_free;
    status.out_free   = out_free;
    status.pend_valid = pend_valid;
    status.fin        = fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= 3'd0;
      fin        <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        u8san_pkg::OP_LOAD: begin
          held[count[1:0]] <= in_data.in_byte;
          count            <= count + 3'd1;
          fin              <= in_data.final_byte;
        end
        u8san_pkg::OP_PUSH_HEAD, u8san_pkg::OP_PUSH_REPL: begin
          if (cmd.op == u8san_pkg::OP_PUSH_HEAD) begin
            for (int i = 0; i < 3; i++) begin
              held[i] <= held[i+1];
            end
            count <= count - 3'd1;
          end
          if (pend_valid) begin
            out_data.out_byte   <= pend_byte;
            out_data.byte_valid <= 1'b1;
            out_data.run_last   <= 1'b0;
            out_data.string_end <= fin;
          end
          pend_byte  <= push_byte;
          pend_valid <= 1'b1;
        end
        u8san_pkg::OP_DROP_HEAD: begin
          for (int i = 0; i < 3; i++) begin
            held[i] <= held[i+1];
          end
          count <= count - 3'd1;
        end
        u8san_pkg::OP_FLUSH: begin
          if (pend_valid) begin
            out_data.out_byte   <= pend_byte;
            out_data.byte_valid <= 1'b1;
            out_data.run_last   <= 1'b1;
            out_data.string_end <= fin;
          end else if (fin) begin
            out_data.out_byte   <= 8'h00;
            out_data.byte_valid <= 1'b0;
            out_data.run_last   <= 1'b1;
            out_data.string_end <= 1'b1;
          end
          pend_valid <= 1'b0;
          if (fin) begin
            count <= 3'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire
